// File: rtl/core/dsi_pkg.sv
package dsi_pkg;

    localparam int BYTE_W  = 8;
    localparam int MAG_W   = 31;
    localparam int VALUE_W = 32;
    localparam int PROD_W  = 35;
    localparam int STAT_W  = 2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_HIGH  = 8'h80;

    localparam logic [BYTE_W-1:0] ALT_SPACE_RST = 8'd25;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_DIGIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_BYTE = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic               past_leading;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic               seen_digit;
        logic               bad_byte;
        logic               overflowed;
    } t_parse_state;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] value;
    } t_result;

endpackage

// File: rtl/core/dsi_parse.sv
module dsi_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [dsi_pkg::BYTE_W-1:0]  i_byte,
    input  logic [dsi_pkg::BYTE_W-1:0]  i_alt_space,
    output logic                        o_res_vld,
    output dsi_pkg::t_result            o_res
);

    dsi_pkg::t_parse_state r_st;
    dsi_pkg::t_parse_state n_st;

    logic                          is_term;
    logic                          is_blank;
    logic                          is_digit;
    logic [dsi_pkg::PROD_W-1:0]    prod;
    logic [dsi_pkg::PROD_W-1:0]    mag_ext;
    logic [dsi_pkg::VALUE_W-1:0]   mag_val;

    assign is_term  = (i_byte == dsi_pkg::CH_NUL);
    assign is_blank = (i_byte == dsi_pkg::CH_SPACE) || (i_byte == dsi_pkg::CH_TAB) ||
                      (i_byte == dsi_pkg::CH_HIGH) || (i_byte == dsi_pkg::CH_APOS) ||
                      (i_byte == i_alt_space);
    assign is_digit = (i_byte >= dsi_pkg::CH_ZERO) && (i_byte <= dsi_pkg::CH_NINE);

    // magnitude * 10 + digit
    assign mag_ext = {{(dsi_pkg::PROD_W-dsi_pkg::MAG_W){1'b0}}, r_st.magnitude};
    assign prod    = (mag_ext << 3) + (mag_ext << 1) +
                     {{(dsi_pkg::PROD_W-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_st = r_st;
        if (is_term) begin
            n_st = '0;
        end else if (!r_st.bad_byte) begin
            if (is_digit && !(!r_st.past_leading && is_blank)) begin
                n_st.past_leading = 1'b1;
                n_st.seen_digit   = 1'b1;
                if (!r_st.overflowed) begin
                    if (prod[dsi_pkg::PROD_W-1:dsi_pkg::MAG_W] != '0) begin
                        n_st.overflowed = 1'b1;
                    end else begin
                        n_st.magnitude = prod[dsi_pkg::MAG_W-1:0];
                    end
                end
            end else if (is_blank) begin
                n_st = r_st;
            end else if (!r_st.past_leading && i_byte == dsi_pkg::CH_MINUS) begin
                n_st.negative     = 1'b1;
                n_st.past_leading = 1'b1;
            end else if (!r_st.past_leading && i_byte == dsi_pkg::CH_PLUS) begin
                n_st.past_leading = 1'b1;
            end else begin
                n_st.bad_byte = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign mag_val   = {1'b0, r_st.magnitude};
    assign o_res_vld = i_step && is_term;

    always_comb begin
        o_res.value = '0;
        priority if (r_st.bad_byte) begin
            o_res.status = dsi_pkg::ST_BAD_BYTE;
        end else if (!r_st.seen_digit) begin
            o_res.status = dsi_pkg::ST_NO_DIGIT;
        end else if (r_st.overflowed) begin
            o_res.status = dsi_pkg::ST_OVERFLOW;
        end else begin
            o_res.status = dsi_pkg::ST_OK;
            o_res.value  = r_st.negative ? -mag_val : mag_val;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.seen_digit |-> r_st.past_leading)
        else $error("digit seen outside the number phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.negative && !r_st.past_leading) == 1'b0)
        else $error("sign taken but still in leading blanks");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.overflowed |-> r_st.seen_digit)
        else $error("overflow without any digit");

endmodule

// File: rtl/core/decimal_string_to_int32_unit.sv
// decimal_string_to_int32_unit
// Parses an ASCII decimal string into a signed 32-bit integer.
// Input channel s_axis: one text byte per request; a zero byte ends the string.
// Output channel m_axis: one result per terminating zero byte, status in tuser
// (0 ok, 1 no digit, 2 bad byte, 3 overflow) and the value in tdata (zero
// unless ok). Leading blanks, one optional sign, digits with blanks between.
// i_cfg_we / i_cfg_wdata write the extra blank byte (reset value 25); write
// only while no string is in progress.
// Throughput: one byte per cycle, except while a zero byte stalls behind a
// waiting result. A result passes one input register, then the digit accumulate
// (times ten plus digit) and status select into the output register.
// Reset clears the parse state and both stage valids, and sets the blank byte
// register back to 25.
// When m_axis_tready is low and a result waits, non-terminator bytes keep
// flowing; a further zero byte waits in the input register and s_axis_tready
// drops until the waiting result is taken.
module decimal_string_to_int32_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dsi_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dsi_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] char_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dsi_pkg::VALUE_W-1:0]   m_axis_tdata,   // [31:0] value
    output logic [dsi_pkg::STAT_W-1:0]    m_axis_tuser    // [1:0] status
);

    logic [dsi_pkg::BYTE_W-1:0] r_alt_space;
    logic                       r_in_vld;
    logic [dsi_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_vld;
    dsi_pkg::t_result           r_out;

    logic             advance;
    logic             res_vld;
    dsi_pkg::t_result res;

    assign advance = r_in_vld &&
                     ((r_in_byte != dsi_pkg::CH_NUL) || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_space <= dsi_pkg::ALT_SPACE_RST;
        end else if (i_cfg_we) begin
            r_alt_space <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    dsi_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_alt_space (r_alt_space),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled without a blocked result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != dsi_pkg::ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero value with error status");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == dsi_pkg::ST_OK) |->
            (m_axis_tdata != {1'b1, {(dsi_pkg::VALUE_W-1){1'b0}}}))
        else $error("most negative value reported as ok");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |=> m_axis_tvalid)
        else $error("result lost on its way to the output register");

endmodule
